>>> hdl/stas_pkg.sv
// ----------------------------------------------------------------------------
// stas_pkg
// shared types and constants of the signed time add/subtract block
// ----------------------------------------------------------------------------
`default_nettype none

package stas_pkg;

  // width of a magnitude in microseconds and of the limit register
  localparam int unsigned MaxW = 42;
  localparam logic [MaxW-1:0] MaxReset = 42'd3020399000000;

  // configuration port
  localparam int unsigned AddrW = 4;
  localparam int unsigned DataW = 64;
  localparam logic RegMaxIdx = 1'b0;

  // microseconds per unit
  localparam logic [31:0] UsPerHour = 32'd3600000000;
  localparam logic [25:0] UsPerMin  = 26'd60000000;
  localparam logic [19:0] UsPerSec  = 20'd1000000;

  // split of the magnitude: each unit is a power of two times an odd part,
  // the power of two is peeled off as low bits
  localparam int unsigned HourLsb = 10;
  localparam int unsigned MinLsb  = 8;
  localparam int unsigned SecLsb  = 6;

  localparam int unsigned HourXW = 32;
  localparam int unsigned MinXW  = 24;
  localparam int unsigned SecXW  = 20;

  localparam longint unsigned HourDiv = 64'd3515625;
  localparam longint unsigned MinDiv  = 64'd234375;
  localparam longint unsigned SecDiv  = 64'd15625;

  localparam int unsigned HourQW = 11;
  localparam int unsigned MinQW  = 7;
  localparam int unsigned SecQW  = 7;
  localparam int unsigned HourRW = 22;
  localparam int unsigned MinRW  = 18;
  localparam int unsigned SecRW  = 14;

  // start to done, in cycles
  localparam int unsigned Latency = 14;

  typedef struct packed {
    logic        neg;
    logic [9:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] micro;
  } atime_t;

  typedef struct packed {
    logic            valid;
    logic            neg;
    logic            ovf;
    logic [MaxW-1:0] mag;
    atime_t          a;
  } front_t;

endpackage

`default_nettype wire

>>> hdl/stas_regs.sv
// ----------------------------------------------------------------------------
// stas_regs
// apb register file holding the magnitude limit
// ----------------------------------------------------------------------------
`default_nettype none

module stas_regs import stas_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready,
  output logic [MaxW-1:0]  max_o
);

  logic [MaxW-1:0] max_q, max_d;
  logic            wr_en;
  logic            hit;

  assign hit   = (paddr[AddrW-1] == RegMaxIdx);
  assign wr_en = psel & penable & pwrite;

  always_comb begin
    max_d = max_q;
    if (wr_en && hit) begin
      max_d = pwdata[MaxW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_q <= MaxReset;
    end else begin
      max_q <= max_d;
    end
  end

  assign prdata = hit ? {{(DataW-MaxW){1'b0}}, max_q} : '0;
  assign pready = 1'b1;
  assign max_o  = max_q;

endmodule

`default_nettype wire

>>> hdl/stas_front.sv
// ----------------------------------------------------------------------------
// stas_front
// four stage front end: unit products, range checks, signed combine
// ----------------------------------------------------------------------------
`default_nettype none

module stas_front import stas_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            valid_i,
  input  atime_t          a_i,
  input  logic            b_neg_i,
  input  logic [31:0]     b_hour_i,
  input  logic [31:0]     b_minute_i,
  input  logic [31:0]     b_second_i,
  input  logic [31:0]     b_micro_i,
  input  logic            sub_i,
  input  logic [MaxW-1:0] max_i,
  output front_t          out_o
);

  // stage 1: products
  logic        v1_q;
  atime_t      a1_q;
  logic        bsub1_q;
  logic [41:0] ah1_q, ah1_d;
  logic [31:0] am1_q, am1_d;
  logic [25:0] as1_q, as1_d;
  logic [63:0] bh1_q, bh1_d;
  logic [57:0] bm1_q, bm1_d;
  logic [51:0] bs1_q, bs1_d;
  logic [31:0] bu1_q;

  assign ah1_d = {32'd0, a_i.hour} * {10'd0, UsPerHour};
  assign am1_d = {26'd0, a_i.minute} * {6'd0, UsPerMin};
  assign as1_d = {20'd0, a_i.second} * {6'd0, UsPerSec};
  assign bh1_d = {32'd0, b_hour_i} * {32'd0, UsPerHour};
  assign bm1_d = {26'd0, b_minute_i} * {32'd0, UsPerMin};
  assign bs1_d = {20'd0, b_second_i} * {32'd0, UsPerSec};

  // stage 2: per-part limit checks and magnitude sums
  logic        v2_q;
  atime_t      a2_q;
  logic        bsub2_q;
  logic        bad2_q, bad2_d;
  logic [42:0] maga2_q, maga2_d;
  logic [43:0] magb2_q, magb2_d;

  assign bad2_d = (bh1_q > {22'd0, max_i}) | (bm1_q > {16'd0, max_i})
                | (bs1_q > {10'd0, max_i}) | ({10'd0, bu1_q} > max_i);
  assign maga2_d = {1'b0, ah1_q} + {11'd0, am1_q} + {17'd0, as1_q}
                 + {23'd0, a1_q.micro};
  assign magb2_d = {2'b0, bh1_q[41:0]} + {2'b0, bm1_q[41:0]}
                 + {2'b0, bs1_q[41:0]} + {12'd0, bu1_q};

  // stage 3: total check on b and sign-magnitude combine
  logic        v3_q;
  atime_t      a3_q;
  logic        bad3_q, bad3_d;
  logic        neg3_q, neg3_d;
  logic [44:0] mag3_q, mag3_d;
  logic [44:0] sum_ab, diff_ab, diff_ba;

  assign bad3_d  = bad2_q | (magb2_q > {2'b0, max_i});
  assign sum_ab  = {2'b0, maga2_q} + {1'b0, magb2_q};
  assign diff_ab = {2'b0, maga2_q} - {1'b0, magb2_q};
  assign diff_ba = {1'b0, magb2_q} - {2'b0, maga2_q};

  always_comb begin
    if (a2_q.neg == bsub2_q) begin
      mag3_d = sum_ab;
      neg3_d = a2_q.neg;
    end else if (diff_ab[44]) begin
      mag3_d = diff_ba;
      neg3_d = bsub2_q;
    end else begin
      mag3_d = diff_ab;
      neg3_d = a2_q.neg;
    end
  end

  // stage 4: result range check, zero is positive
  front_t out_q, out_d;

  always_comb begin
    out_d.valid = v3_q;
    out_d.ovf   = bad3_q | (mag3_q > {3'b0, max_i});
    out_d.neg   = neg3_q & (mag3_q != 45'd0);
    out_d.mag   = mag3_q[MaxW-1:0];
    out_d.a     = a3_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q  <= 1'b0;
      v2_q  <= 1'b0;
      v3_q  <= 1'b0;
      out_q <= '0;
    end else begin
      v1_q  <= valid_i;
      v2_q  <= v1_q;
      v3_q  <= v2_q;
      out_q <= out_d;
    end
  end

  always_ff @(posedge clk_i) begin
    a1_q      <= a_i;
    bsub1_q   <= b_neg_i ^ sub_i;
    ah1_q     <= ah1_d;
    am1_q     <= am1_d;
    as1_q     <= as1_d;
    bh1_q     <= bh1_d;
    bm1_q     <= bm1_d;
    bs1_q     <= bs1_d;
    bu1_q     <= b_micro_i;
    a2_q      <= a1_q;
    bsub2_q   <= bsub1_q;
    bad2_q    <= bad2_d;
    maga2_q   <= maga2_d;
    magb2_q   <= magb2_d;
    a3_q      <= a2_q;
    bad3_q    <= bad3_d;
    neg3_q    <= neg3_d;
    mag3_q    <= mag3_d;
  end

  assign out_o = out_q;

  // a zero sum never leaves with a minus sign
  a_zero_pos: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_q.valid && !out_q.ovf && out_q.mag == '0) |-> !out_q.neg)
    else $error("negative zero result");

endmodule

`default_nettype wire

>>> hdl/stas_cdiv.sv
// ----------------------------------------------------------------------------
// stas_cdiv
// three stage divider by a constant: reciprocal estimate, remainder, fix-up
// ----------------------------------------------------------------------------
`default_nettype none

module stas_cdiv #(
  parameter int unsigned     XW  = 32,
  parameter longint unsigned DIV = 64'd3515625,
  parameter int unsigned     SW  = 1,
  localparam longint unsigned QMax = ((64'd1 << XW) - 64'd1) / DIV,
  localparam int unsigned     QW   = $clog2(QMax + 64'd1),
  localparam int unsigned     RW   = $clog2(DIV)
) (
  input  logic          clk_i,
  input  logic          rst_ni,
  input  logic          valid_i,
  input  logic [XW-1:0] x_i,
  input  logic [SW-1:0] side_i,
  output logic          valid_o,
  output logic [QW-1:0] q_o,
  output logic [RW-1:0] r_o,
  output logic [SW-1:0] side_o
);

  localparam longint unsigned MulC = (64'd1 << XW) / DIV;
  localparam int unsigned     MW   = $clog2(MulC + 64'd1);
  localparam int unsigned     PW   = XW + MW;

  // estimate is the true quotient or one below
  logic [PW-1:0] prod;
  logic          v1_q;
  logic [QW-1:0] q1_q;
  logic [XW-1:0] x1_q;
  logic [SW-1:0] s1_q;

  assign prod = PW'(x_i) * PW'(MulC);

  // remainder of the estimate, below twice the divisor
  logic [XW-1:0] qd;
  logic [XW-1:0] diff;
  logic          v2_q;
  logic [QW-1:0] q2_q;
  logic [RW:0]   r2_q;
  logic [SW-1:0] s2_q;

  assign qd   = XW'(q1_q) * XW'(DIV);
  assign diff = x1_q - qd;

  // one correction step
  logic          v3_q;
  logic [QW-1:0] q3_q, q3_d;
  logic [RW-1:0] r3_q, r3_d;
  logic [SW-1:0] s3_q;

  always_comb begin
    if (r2_q >= (RW+1)'(DIV)) begin
      q3_d = q2_q + QW'(1);
      r3_d = RW'(r2_q - (RW+1)'(DIV));
    end else begin
      q3_d = q2_q;
      r3_d = r2_q[RW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
    end else begin
      v1_q <= valid_i;
      v2_q <= v1_q;
      v3_q <= v2_q;
    end
  end

  always_ff @(posedge clk_i) begin
    q1_q <= prod[XW +: QW];
    x1_q <= x_i;
    s1_q <= side_i;
    q2_q <= q1_q;
    r2_q <= diff[RW:0];
    s2_q <= s1_q;
    q3_q <= q3_d;
    r3_q <= r3_d;
    s3_q <= s2_q;
  end

  assign valid_o = v3_q;
  assign q_o     = q3_q;
  assign r_o     = r3_q;
  assign side_o  = s3_q;

  a_rem_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q |-> (64'(r3_q) < DIV))
    else $error("remainder not below divisor");

endmodule

`default_nettype wire

>>> hdl/signed_time_add_subtract_top.sv
// ----------------------------------------------------------------------------
// signed_time_add_subtract_top
// adds or subtracts a signed time span to or from a signed time value
// ----------------------------------------------------------------------------
// A new operand pair can be started in every clock cycle; busy stays low. Each
// start gives exactly one result, shown with done_o for a single cycle once
// it has passed through the whole pipeline, in start order. The receiver cannot
// stall, so results must be taken as they come. The pipeline
// holds four front stages (unit products, per-part limit checks and sums,
// signed combine, result range check), three 3-stage constant dividers that
// split the magnitude into hours, minutes and seconds, and the output
// register. When overflow_o is set the result fields repeat operand A.
// The limit max_magnitude_us sits at byte address 0 of the apb port (64-bit
// data, low 42 bits used) and should only be written while no item is in
// flight.
// ----------------------------------------------------------------------------
`default_nettype none

module signed_time_add_subtract_top import stas_pkg::*; (
  input  logic             clk_i,
  input  logic             rst_ni,
  // command channel
  input  logic             start,
  output logic             busy,
  input  logic             a_negative_i,
  input  logic [9:0]       a_hour_i,
  input  logic [5:0]       a_minute_i,
  input  logic [5:0]       a_second_i,
  input  logic [19:0]      a_micro_i,
  input  logic             b_negative_i,
  input  logic [31:0]      b_hour_i,
  input  logic [31:0]      b_minute_i,
  input  logic [31:0]      b_second_i,
  input  logic [31:0]      b_micro_i,
  input  logic             subtract_i,
  // result channel
  output logic             done_o,
  output logic             res_negative_o,
  output logic [9:0]       res_hour_o,
  output logic [5:0]       res_minute_o,
  output logic [5:0]       res_second_o,
  output logic [19:0]      res_micro_o,
  output logic             overflow_o,
  // configuration port
  input  logic             psel,
  input  logic             penable,
  input  logic             pwrite,
  input  logic [AddrW-1:0] paddr,
  input  logic [DataW-1:0] pwdata,
  output logic [DataW-1:0] prdata,
  output logic             pready
);

  // fields that ride along with the dividers
  typedef struct packed {
    logic   neg;
    logic   ovf;
    atime_t a;
  } hdr_t;

  typedef struct packed {
    hdr_t                 hdr;
    logic [HourLsb-1:0]   low;
  } sh_t;

  typedef struct packed {
    hdr_t                 hdr;
    logic [HourQW-1:0]    qh;
    logic [MinLsb-1:0]    low;
  } sm_t;

  typedef struct packed {
    hdr_t                 hdr;
    logic [HourQW-1:0]    qh;
    logic [MinQW-1:0]     qm;
    logic [SecLsb-1:0]    low;
  } ss_t;

  logic [MaxW-1:0] max_us;
  logic            accept;
  atime_t          a_in;
  front_t          fr;

  // every cycle is open for a new transfer
  assign busy   = 1'b0;
  assign accept = start & ~busy;

  stas_regs u_regs (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .max_o   (max_us)
  );

  always_comb begin
    a_in.neg    = a_negative_i;
    a_in.hour   = a_hour_i;
    a_in.minute = a_minute_i;
    a_in.second = a_second_i;
    a_in.micro  = a_micro_i;
  end

  // conversion to microseconds, checks, signed sum
  stas_front u_front (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (accept),
    .a_i        (a_in),
    .b_neg_i    (b_negative_i),
    .b_hour_i   (b_hour_i),
    .b_minute_i (b_minute_i),
    .b_second_i (b_second_i),
    .b_micro_i  (b_micro_i),
    .sub_i      (subtract_i),
    .max_i      (max_us),
    .out_o      (fr)
  );

  // hours: magnitude / 3600e6, low bits of the power-of-two factor bypass
  sh_t               sh_in, sh_out;
  logic              vh;
  logic [HourQW-1:0] qh;
  logic [HourRW-1:0] rh;

  always_comb begin
    sh_in.hdr.neg = fr.neg;
    sh_in.hdr.ovf = fr.ovf;
    sh_in.hdr.a   = fr.a;
    sh_in.low     = fr.mag[HourLsb-1:0];
  end

  stas_cdiv #(
    .XW  (HourXW),
    .DIV (HourDiv),
    .SW  ($bits(sh_t))
  ) u_div_hour (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (fr.valid),
    .x_i     (fr.mag[MaxW-1:HourLsb]),
    .side_i  (sh_in),
    .valid_o (vh),
    .q_o     (qh),
    .r_o     (rh),
    .side_o  (sh_out)
  );

  // minutes: remainder of the hour / 60e6
  sm_t               sm_in, sm_out;
  logic              vm;
  logic [MinQW-1:0]  qm;
  logic [MinRW-1:0]  rm;
  logic [MinXW-1:0]  xm;

  assign xm = {rh, sh_out.low[HourLsb-1:MinLsb]};

  always_comb begin
    sm_in.hdr = sh_out.hdr;
    sm_in.qh  = qh;
    sm_in.low = sh_out.low[MinLsb-1:0];
  end

  stas_cdiv #(
    .XW  (MinXW),
    .DIV (MinDiv),
    .SW  ($bits(sm_t))
  ) u_div_min (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vh),
    .x_i     (xm),
    .side_i  (sm_in),
    .valid_o (vm),
    .q_o     (qm),
    .r_o     (rm),
    .side_o  (sm_out)
  );

  // seconds: remainder of the minute / 1e6
  ss_t               ss_in, ss_out;
  logic              vs;
  logic [SecQW-1:0]  qs;
  logic [SecRW-1:0]  rs;
  logic [SecXW-1:0]  xs;

  assign xs = {rm, sm_out.low[MinLsb-1:SecLsb]};

  always_comb begin
    ss_in.hdr = sm_out.hdr;
    ss_in.qh  = sm_out.qh;
    ss_in.qm  = qm;
    ss_in.low = sm_out.low[SecLsb-1:0];
  end

  stas_cdiv #(
    .XW  (SecXW),
    .DIV (SecDiv),
    .SW  ($bits(ss_t))
  ) u_div_sec (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .valid_i (vm),
    .x_i     (xs),
    .side_i  (ss_in),
    .valid_o (vs),
    .q_o     (qs),
    .r_o     (rs),
    .side_o  (ss_out)
  );

  // output register: on overflow operand a goes back out untouched
  logic        done_q;
  logic        neg_q, neg_d;
  logic [9:0]  hour_q, hour_d;
  logic [5:0]  min_q, min_d;
  logic [5:0]  sec_q, sec_d;
  logic [19:0] micro_q, micro_d;
  logic        ovf_q;

  always_comb begin
    if (ss_out.hdr.ovf) begin
      neg_d   = ss_out.hdr.a.neg;
      hour_d  = ss_out.hdr.a.hour;
      min_d   = ss_out.hdr.a.minute;
      sec_d   = ss_out.hdr.a.second;
      micro_d = ss_out.hdr.a.micro;
    end else begin
      neg_d   = ss_out.hdr.neg;
      hour_d  = ss_out.qh[9:0];
      min_d   = ss_out.qm[5:0];
      sec_d   = qs[5:0];
      micro_d = {rs, ss_out.low};
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= vs;
    end
  end

  always_ff @(posedge clk_i) begin
    neg_q   <= neg_d;
    hour_q  <= hour_d;
    min_q   <= min_d;
    sec_q   <= sec_d;
    micro_q <= micro_d;
    ovf_q   <= ss_out.hdr.ovf;
  end

  assign done_o         = done_q;
  assign res_negative_o = neg_q;
  assign res_hour_o     = hour_q;
  assign res_minute_o   = min_q;
  assign res_second_o   = sec_q;
  assign res_micro_o    = micro_q;
  assign overflow_o     = ovf_q;

  // each start transfer comes out after the fixed pipeline depth
  a_start_done: assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |-> ##Latency done_o)
    else $error("start transfer lost in pipeline");

  // no result without a matching start
  a_done_start: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> $past(accept, Latency))
    else $error("result without start transfer");

  // overflow hands operand a back unchanged
  a_ovf_pass: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && overflow_o) |->
      (res_hour_o == $past(a_hour_i, Latency)) &&
      (res_micro_o == $past(a_micro_i, Latency)) &&
      (res_negative_o == $past(a_negative_i, Latency)))
    else $error("overflow result differs from operand a");

endmodule

`default_nettype wire

>>> tb/signed_time_add_subtract_top_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// signed_time_add_subtract_top_tb
// self-checking bench for the signed time add/subtract block: a local
// predictor works out every result from the operands and the current limit,
// a monitor compares each done_o transfer field by field against the oldest
// prediction, under several limit settings and random idling of the sender
// ----------------------------------------------------------------------------
module signed_time_add_subtract_top_tb import stas_pkg::*;;

  typedef longint unsigned u64_t;
  typedef longint          s64_t;

  // operation codes on subtract_i
  localparam logic OpAdd = 1'b0;
  localparam logic OpSub = 1'b1;

  // byte address of the limit register (64-bit data, so 8 bytes per register)
  localparam logic [AddrW-1:0] LimitAddr = AddrW'(8 * RegMaxIdx);

  // microseconds per unit, widened for the predictor
  localparam u64_t UsHour = u64_t'(UsPerHour);
  localparam u64_t UsMin  = u64_t'(UsPerMin);
  localparam u64_t UsSec  = u64_t'(UsPerSec);
  localparam u64_t LimitTop = (u64_t'(1) << MaxW) - 1;

  // generous watchdog on the length of the whole run
  localparam int unsigned CycleLimit = 200000;

  // one operand pair as it goes into the block
  typedef struct {
    logic        a_neg;
    logic [9:0]  a_hour;
    logic [5:0]  a_min;
    logic [5:0]  a_sec;
    logic [19:0] a_micro;
    logic        b_neg;
    logic [31:0] b_hour;
    logic [31:0] b_min;
    logic [31:0] b_sec;
    logic [31:0] b_micro;
    logic        sub;
  } time_pair_t;

  // one predicted sum as it comes out of the block
  typedef struct {
    logic        neg;
    logic [9:0]  hour;
    logic [5:0]  minute;
    logic [5:0]  second;
    logic [19:0] micro;
    logic        ovf;
  } time_sum_t;

  logic             clk_i;
  logic             rst_ni;
  logic             start;
  logic             busy;
  logic             a_negative_i;
  logic [9:0]       a_hour_i;
  logic [5:0]       a_minute_i;
  logic [5:0]       a_second_i;
  logic [19:0]      a_micro_i;
  logic             b_negative_i;
  logic [31:0]      b_hour_i;
  logic [31:0]      b_minute_i;
  logic [31:0]      b_second_i;
  logic [31:0]      b_micro_i;
  logic             subtract_i;
  logic             done_o;
  logic             res_negative_o;
  logic [9:0]       res_hour_o;
  logic [5:0]       res_minute_o;
  logic [5:0]       res_second_o;
  logic [19:0]      res_micro_o;
  logic             overflow_o;
  logic             psel;
  logic             penable;
  logic             pwrite;
  logic [AddrW-1:0] paddr;
  logic [DataW-1:0] pwdata;
  logic [DataW-1:0] prdata;
  logic             pready;

  // predictor state: the limit as the block should currently hold it
  logic [MaxW-1:0] limit_model;
  // predicted sums, oldest first
  time_sum_t       expected_sums[$];
  time_sum_t       want_sum;

  // sender idling on or off, toggled to get back-to-back stretches
  bit              idle_en;

  int unsigned     error_count;
  int unsigned     items_sent;
  int unsigned     results_seen;
  int unsigned     overflows_seen;
  int unsigned     config_writes;
  int unsigned     cycle_count;

  signed_time_add_subtract_top dut (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .start          (start),
    .busy           (busy),
    .a_negative_i   (a_negative_i),
    .a_hour_i       (a_hour_i),
    .a_minute_i     (a_minute_i),
    .a_second_i     (a_second_i),
    .a_micro_i      (a_micro_i),
    .b_negative_i   (b_negative_i),
    .b_hour_i       (b_hour_i),
    .b_minute_i     (b_minute_i),
    .b_second_i     (b_second_i),
    .b_micro_i      (b_micro_i),
    .subtract_i     (subtract_i),
    .done_o         (done_o),
    .res_negative_o (res_negative_o),
    .res_hour_o     (res_hour_o),
    .res_minute_o   (res_minute_o),
    .res_second_o   (res_second_o),
    .res_micro_o    (res_micro_o),
    .overflow_o     (overflow_o),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  // 12 ns clock
  initial clk_i = 1'b0;
  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // watchdog
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CycleLimit) begin
      $display("timeout after %0d cycles, %0d predictions open", cycle_count,
               expected_sums.size());
      $display("Simulation FAILED");
      $finish;
    end
  end

  // one line per mismatch, printing capped but every one counted
  task automatic report_mismatch(input string msg);
    if (error_count < 40) $display("[%0t] mismatch: %s", $time, msg);
    error_count++;
  endtask

  task automatic check_field(input string name, input u64_t got, input u64_t want);
    if (got != want)
      report_mismatch($sformatf("result %0d %s got %0d expected %0d",
                                results_seen, name, got, want));
  endtask

  // expected sum of one pair under the given limit
  function automatic time_sum_t predict_time_sum(time_pair_t p, logic [MaxW-1:0] lim);
    u64_t      lim_w;
    u64_t      mag_a;
    u64_t      mag_b;
    u64_t      mag;
    u64_t      cnt[4];
    u64_t      unit[4];
    s64_t      sum;
    bit        bad;
    time_sum_t r;
    lim_w = u64_t'(lim);
    bad   = 1'b0;
    mag_b = 0;
    mag   = 0;
    r.neg = 1'b0;
    // A is taken as given, out-of-range fields included
    mag_a = u64_t'(p.a_hour) * UsHour + u64_t'(p.a_min) * UsMin +
            u64_t'(p.a_sec) * UsSec + u64_t'(p.a_micro);
    // each part of B is checked against the limit in its own unit
    cnt  = '{u64_t'(p.b_micro), u64_t'(p.b_sec), u64_t'(p.b_min), u64_t'(p.b_hour)};
    unit = '{u64_t'(1), UsSec, UsMin, UsHour};
    foreach (cnt[i]) begin
      if (cnt[i] > lim_w / unit[i]) bad = 1'b1;
      else mag_b += cnt[i] * unit[i];
    end
    if (mag_b > lim_w) bad = 1'b1;
    if (!bad) begin
      sum = p.a_neg ? -s64_t'(mag_a) : s64_t'(mag_a);
      if (p.b_neg ^ p.sub) sum -= s64_t'(mag_b);
      else sum += s64_t'(mag_b);
      // a zero sum counts as positive
      r.neg = (sum < 0);
      mag = r.neg ? u64_t'(-sum) : u64_t'(sum);
      if (mag > lim_w) bad = 1'b1;
    end
    if (bad) begin
      r = '{p.a_neg, p.a_hour, p.a_min, p.a_sec, p.a_micro, 1'b1};
    end else begin
      // hours wrap to 10 bits when the limit allows more
      r.hour   = 10'(mag / UsHour);
      mag      = mag % UsHour;
      r.minute = 6'(mag / UsMin);
      mag      = mag % UsMin;
      r.second = 6'(mag / UsSec);
      r.micro  = 20'(mag % UsSec);
      r.ovf    = 1'b0;
    end
    return r;
  endfunction

  function automatic time_pair_t mk_pair(logic an, logic [9:0] ah, logic [5:0] am,
                                         logic [5:0] as_, logic [19:0] au, logic bn,
                                         logic [31:0] bh, logic [31:0] bm,
                                         logic [31:0] bs, logic [31:0] bu, logic op);
    time_pair_t p;
    p = '{an, ah, am, as_, au, bn, bh, bm, bs, bu, op};
    return p;
  endfunction

  // random pair: mostly in-range spans, plus limit boundaries and raw bits
  function automatic time_pair_t rand_pair(logic [MaxW-1:0] lim);
    time_pair_t  p;
    int unsigned sel;
    int unsigned part;
    u64_t        edge_cnt;
    u64_t        unit_sel;
    p.a_neg = 1'($urandom);
    p.b_neg = 1'($urandom);
    p.sub   = $urandom_range(0, 1) ? OpSub : OpAdd;
    if ($urandom_range(0, 99) < 85) begin
      p.a_hour  = 10'($urandom_range(0, 838));
      p.a_min   = 6'($urandom_range(0, 59));
      p.a_sec   = 6'($urandom_range(0, 59));
      p.a_micro = 20'($urandom_range(0, 999999));
    end else begin
      p.a_hour  = 10'($urandom);
      p.a_min   = 6'($urandom);
      p.a_sec   = 6'($urandom);
      p.a_micro = 20'($urandom);
    end
    sel = $urandom_range(0, 99);
    if (sel < 60) begin
      p.b_hour  = $urandom_range(0, 900);
      p.b_min   = $urandom_range(0, 120);
      p.b_sec   = $urandom_range(0, 120);
      p.b_micro = $urandom_range(0, 2000000);
    end else if (sel < 80) begin
      // one part sits just around its own limit, the rest are zero
      part = $urandom_range(0, 3);
      unit_sel = (part == 0) ? u64_t'(1) : (part == 1) ? UsSec :
                 (part == 2) ? UsMin : UsHour;
      edge_cnt = u64_t'(lim) / unit_sel + $urandom_range(0, 2);
      edge_cnt = (edge_cnt == 0) ? 0 : edge_cnt - 1;
      if (edge_cnt > 64'hFFFF_FFFF) edge_cnt = 64'hFFFF_FFFF;
      p.b_hour  = (part == 3) ? 32'(edge_cnt) : '0;
      p.b_min   = (part == 2) ? 32'(edge_cnt) : '0;
      p.b_sec   = (part == 1) ? 32'(edge_cnt) : '0;
      p.b_micro = (part == 0) ? 32'(edge_cnt) : '0;
    end else if (sel < 90) begin
      p.b_hour  = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50);
      p.b_min   = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50);
      p.b_sec   = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50);
      p.b_micro = $urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 50);
    end else begin
      p.b_hour  = $urandom;
      p.b_min   = $urandom;
      p.b_sec   = $urandom;
      p.b_micro = $urandom;
    end
    return p;
  endfunction

  // one start transfer; start stays high when the next item follows at once
  task automatic send_pair(input time_pair_t p);
    int unsigned gap;
    gap = idle_en ? $urandom_range(0, 5) : 0;
    @(negedge clk_i);
    repeat (gap) begin
      start = 1'b0;
      @(negedge clk_i);
    end
    a_negative_i = p.a_neg;
    a_hour_i     = p.a_hour;
    a_minute_i   = p.a_min;
    a_second_i   = p.a_sec;
    a_micro_i    = p.a_micro;
    b_negative_i = p.b_neg;
    b_hour_i     = p.b_hour;
    b_minute_i   = p.b_min;
    b_second_i   = p.b_sec;
    b_micro_i    = p.b_micro;
    subtract_i   = p.sub;
    start        = 1'b1;
    do @(posedge clk_i); while (busy);
    expected_sums.push_back(predict_time_sum(p, limit_model));
    items_sent++;
  endtask

  // stop sending and wait until every prediction has been matched
  task automatic drain_results();
    @(negedge clk_i);
    start = 1'b0;
    while (expected_sums.size() != 0) @(posedge clk_i);
    repeat (Latency + 2) @(posedge clk_i);
  endtask

  task automatic read_limit();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b0;
    paddr   = LimitAddr;
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[MaxW-1:0] !== limit_model)
      report_mismatch($sformatf("limit readback got %0d expected %0d",
                                prdata[MaxW-1:0], limit_model));
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
  endtask

  // limit write while idle; bits above the register width are junk on purpose
  task automatic write_limit(input u64_t value);
    drain_results();
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = 1'b1;
    paddr   = LimitAddr;
    pwdata  = {22'($urandom), value[MaxW-1:0]};
    @(negedge clk_i);
    penable = 1'b1;
    do @(posedge clk_i); while (!pready);
    limit_model = value[MaxW-1:0];
    config_writes++;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
    read_limit();
  endtask

  // result monitor: every done_o transfer is matched against the oldest prediction
  always @(posedge clk_i) begin
    if (rst_ni && done_o) begin
      if (expected_sums.size() == 0) begin
        report_mismatch("result transfer with no prediction open");
      end else begin
        want_sum = expected_sums.pop_front();
        check_field("res_negative", res_negative_o, want_sum.neg);
        check_field("res_hour", res_hour_o, want_sum.hour);
        check_field("res_minute", res_minute_o, want_sum.minute);
        check_field("res_second", res_second_o, want_sum.second);
        check_field("res_micro", res_micro_o, want_sum.micro);
        check_field("overflow", overflow_o, want_sum.ovf);
        if (want_sum.ovf) overflows_seen++;
        results_seen++;
      end
    end
  end

  // reset limit: extremes, signs, zero results and every overflow cause
  task automatic test_reset_limit();
    read_limit();
    idle_en = 1'b1;
    // zero in, zero out
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 0, OpAdd));
    // exactly the limit, then one microsecond past it either way
    send_pair(mk_pair(0, 838, 59, 59, 0, 0, 0, 0, 0, 0, OpAdd));
    send_pair(mk_pair(0, 838, 59, 59, 0, 0, 0, 0, 0, 1, OpAdd));
    send_pair(mk_pair(1, 838, 59, 59, 0, 0, 0, 0, 0, 1, OpSub));
    // subtracting a negative span adds
    send_pair(mk_pair(1, 838, 59, 59, 0, 1, 0, 0, 0, 1, OpSub));
    // sign flips to negative
    send_pair(mk_pair(0, 1, 0, 0, 0, 0, 2, 0, 0, 0, OpSub));
    // sums of zero come out positive
    send_pair(mk_pair(1, 0, 0, 0, 500000, 0, 0, 0, 0, 500000, OpAdd));
    send_pair(mk_pair(1, 0, 0, 0, 0, 1, 0, 0, 0, 0, OpAdd));
    // hours of B on both sides of their own limit
    send_pair(mk_pair(1, 838, 59, 59, 0, 0, 838, 0, 0, 0, OpAdd));
    send_pair(mk_pair(0, 12, 34, 56, 789012, 0, 839, 0, 0, 0, OpAdd));
    // minutes of B on both sides
    send_pair(mk_pair(1, 0, 0, 0, 0, 0, 0, 50339, 0, 0, OpSub));
    send_pair(mk_pair(0, 0, 0, 0, 0, 1, 0, 50340, 0, 0, OpAdd));
    // seconds of B on both sides
    send_pair(mk_pair(0, 838, 59, 59, 0, 0, 0, 0, 3020399, 0, OpSub));
    send_pair(mk_pair(0, 3, 2, 1, 0, 0, 0, 0, 3020400, 0, OpSub));
    // all-ones microseconds of B still fit
    send_pair(mk_pair(0, 5, 6, 7, 8, 1, 0, 0, 0, 32'hFFFF_FFFF, OpSub));
    // parts fit one by one but B's total is over the limit
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 838, 59, 59, 1, OpAdd));
    // every bit of B set
    send_pair(mk_pair(1, 1023, 63, 63, 20'hFFFFF, 1, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
                      32'hFFFF_FFFF, 32'hFFFF_FFFF, OpSub));
    // out-of-range A fields are used as given
    send_pair(mk_pair(0, 1023, 63, 63, 20'hFFFFF, 0, 838, 0, 0, 0, OpSub));
    send_pair(mk_pair(1, 1023, 63, 63, 20'hFFFFF, 0, 0, 0, 0, 0, OpAdd));
  endtask

  // zero limit: only a zero sum gets through
  task automatic test_zero_limit();
    write_limit(0);
    send_pair(mk_pair(0, 0, 0, 0, 0, 1, 0, 0, 0, 0, OpSub));
    send_pair(mk_pair(1, 0, 0, 0, 1, 0, 0, 0, 0, 0, OpAdd));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 0, 0, 1, OpAdd));
  endtask

  // all-ones limit: hour counts beyond 10 bits wrap
  task automatic test_full_limit();
    write_limit(LimitTop);
    send_pair(mk_pair(0, 1023, 63, 63, 20'hFFFFF, 0, 100, 0, 0, 0, OpAdd));
    send_pair(mk_pair(1, 1023, 63, 63, 20'hFFFFF, 0, 100, 0, 0, 0, OpSub));
    send_pair(mk_pair(0, 0, 0, 0, 0, 0, 0, 32'hFFFF_FFFF, 0, 0, OpAdd));
  endtask

  // back-to-back burst, a full drain with the sender held off, then a burst with idling
  task automatic test_burst_and_drain();
    write_limit(MaxReset);
    idle_en = 1'b0;
    repeat (40) send_pair(rand_pair(limit_model));
    // sender holds off until every prediction has been matched
    drain_results();
    idle_en = 1'b1;
    repeat (40) send_pair(rand_pair(limit_model));
  endtask

  // random pairs under a sweep of limits, idling switched in stretches
  task automatic test_random_limits();
    u64_t lims[6];
    lims[0] = u64_t'(MaxReset);
    lims[1] = {$urandom, $urandom} & LimitTop;
    lims[2] = u64_t'($urandom_range(0, 32'hFFFF_FFFF));
    lims[3] = LimitTop;
    lims[4] = u64_t'(MaxReset) + $urandom_range(0, 4000000000);
    lims[5] = 64'd1000000000000 + ({$urandom, $urandom} % 64'd3000000000000);
    foreach (lims[k]) begin
      write_limit(lims[k]);
      for (int n = 0; n < 87; n++) begin
        if (n % 29 == 0) idle_en = $urandom_range(0, 1);
        send_pair(rand_pair(limit_model));
      end
    end
  endtask

  initial begin
    // every input known from time zero while reset is held
    rst_ni       = 1'b0;
    start        = 1'b0;
    a_negative_i = 1'b0;
    a_hour_i     = '0;
    a_minute_i   = '0;
    a_second_i   = '0;
    a_micro_i    = '0;
    b_negative_i = 1'b0;
    b_hour_i     = '0;
    b_minute_i   = '0;
    b_second_i   = '0;
    b_micro_i    = '0;
    subtract_i   = OpAdd;
    psel         = 1'b0;
    penable      = 1'b0;
    pwrite       = 1'b0;
    paddr        = '0;
    pwdata       = '0;
    limit_model  = MaxReset;
    idle_en      = 1'b1;
    repeat (11) @(negedge clk_i);
    rst_ni = 1'b1;

    test_reset_limit();
    test_zero_limit();
    test_full_limit();
    test_burst_and_drain();
    test_random_limits();

    // let the pipeline empty out before judging
    drain_results();
    $display("sent %0d operand pairs, checked %0d sums (%0d with overflow)",
             items_sent, results_seen, overflows_seen);
    $display("limit register written %0d times, zero and all-ones included",
             config_writes);
    if (error_count == 0 && expected_sums.size() == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("%0d mismatches, %0d predictions left open", error_count,
               expected_sums.size());
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

>>> files.f
hdl/stas_pkg.sv
hdl/stas_regs.sv
hdl/stas_front.sv
hdl/stas_cdiv.sv
hdl/signed_time_add_subtract_top.sv
tb/signed_time_add_subtract_top_tb.sv
